// File: design/refractive_index_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Refractive index interpolator assertion macros
// Concurrent assertion forms used by the interpolator controller.
// ----------------------------------------------------------------------------
`ifndef REFRACTIVE_INDEX_INTERPOLATOR_ASSERT_SVH
`define REFRACTIVE_INDEX_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication under reset.
`define RII_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define RII_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rii_pkg.sv
// ----------------------------------------------------------------------------
// rii_pkg
// Widths, status codes, optical table ROM and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rii_pkg;

    localparam int WAVE_W            = 16;
    localparam int INDEX_W           = 19;
    localparam int STATUS_W          = 2;
    localparam int ROM_DEPTH         = 14;
    localparam int IDX_W             = $clog2(ROM_DEPTH);
    localparam int TABLE_ENTRIES_DEF = 14;
    localparam int PROD_W            = WAVE_W + INDEX_W;
    localparam int NUM_W             = PROD_W + 1;
    localparam int DIV_STEPS         = INDEX_W;
    localparam int CNT_W             = $clog2(DIV_STEPS);

    localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOW    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIGH   = 2'd2;

    typedef struct packed {
        logic load;
        logic seg_next;
        logic load_mul;
        logic load_div;
        logic div_step;
        logic emit_clamp;
        logic emit_interp;
    } rii_cmd_t;

    typedef struct packed {
        logic below;
        logic above;
        logic seg_hit;
        logic div_last;
    } rii_stat_t;

    function automatic logic [WAVE_W-1:0] rom_wave(input logic [IDX_W-1:0] idx);
        logic [WAVE_W-1:0] w;
        case (idx)
            4'd0:    w = 16'd1240;
            4'd1:    w = 16'd1378;
            4'd2:    w = 16'd1550;
            4'd3:    w = 16'd1771;
            4'd4:    w = 16'd2066;
            4'd5:    w = 16'd2480;
            4'd6:    w = 16'd2755;
            4'd7:    w = 16'd3100;
            4'd8:    w = 16'd3543;
            4'd9:    w = 16'd4133;
            4'd10:   w = 16'd4960;
            4'd11:   w = 16'd6199;
            4'd12:   w = 16'd8190;
            4'd13:   w = 16'd9613;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [INDEX_W-1:0] rom_re(input logic [IDX_W-1:0] idx);
        logic [INDEX_W-1:0] v;
        case (idx)
            4'd0:    v = 19'd30540;
            4'd1:    v = 19'd32702;
            4'd2:    v = 19'd36307;
            4'd3:    v = 19'd43909;
            4'd4:    v = 19'd62980;
            4'd5:    v = 19'd108790;
            4'd6:    v = 19'd151388;
            4'd7:    v = 19'd220201;
            4'd8:    v = 19'd300810;
            4'd9:    v = 19'd355860;
            4'd10:   v = 19'd344064;
            4'd11:   v = 19'd308675;
            4'd12:   v = 19'd255590;
            4'd13:   v = 19'd239862;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [INDEX_W-1:0] rom_im(input logic [IDX_W-1:0] idx);
        logic [INDEX_W-1:0] v;
        case (idx)
            4'd0:    v = 19'd71434;
            4'd1:    v = 19'd87163;
            4'd2:    v = 19'd108790;
            4'd3:    v = 19'd136315;
            4'd4:    v = 19'd173670;
            4'd5:    v = 19'd221512;
            4'd6:    v = 19'd243139;
            4'd7:    v = 19'd256901;
            4'd8:    v = 19'd221512;
            4'd9:    v = 19'd143524;
            4'd10:   v = 19'd65012;
            4'd11:   v = 19'd14221;
            4'd12:   v = 19'd1461;
            4'd13:   v = 19'd721;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/rii_datapath.sv
// ----------------------------------------------------------------------------
// rii_datapath
// Segment search, weighted sums and two bit-serial restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module rii_datapath
    import rii_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [WAVE_W-1:0]   wavelength,
    input  wire rii_cmd_t            cmd,
    output rii_stat_t                st,
    output logic [INDEX_W-1:0]       index_real,
    output logic [INDEX_W-1:0]       index_imag,
    output logic [STATUS_W-1:0]      range_status
);

    localparam int COUNT = (TABLE_ENTRIES > ROM_DEPTH) ? ROM_DEPTH :
                           ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COUNT - 1);

    logic [IDX_W-1:0]    idx_reg,   idx_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [WAVE_W-1:0]   x_reg;
    logic [WAVE_W-1:0]   to_hi_reg, from_lo_reg, width_reg;
    logic [WAVE_W-1:0]   rem_re_reg, rem_im_reg;
    logic [INDEX_W-1:0]  nq_re_reg,  nq_im_reg;
    logic [INDEX_W-1:0]  real_reg,   imag_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [IDX_W-1:0]    idx_up;
    logic [WAVE_W-1:0]   w_lo, w_hi;
    logic [INDEX_W-1:0]  re_lo, re_hi, im_lo, im_hi;
    logic [NUM_W-1:0]    sum_re, sum_im;
    logic [WAVE_W:0]     step_re, step_im;
    logic                width_zero;

    function automatic logic [WAVE_W:0] div_bit(
        input logic [WAVE_W-1:0] rem,
        input logic              nbit,
        input logic [WAVE_W-1:0] dvs
    );
        logic [WAVE_W:0] trial;
        logic [WAVE_W:0] diff;
        logic            ge;
        trial = {rem, nbit};
        diff  = trial - {1'b0, dvs};
        ge    = trial >= {1'b0, dvs};
        return ge ? {1'b1, diff[WAVE_W-1:0]} : {1'b0, trial[WAVE_W-1:0]};
    endfunction

    assign idx_up = idx_reg + 1'b1;
    assign w_lo   = rom_wave(idx_reg);
    assign w_hi   = rom_wave(idx_up);
    assign re_lo  = rom_re(idx_reg);
    assign re_hi  = rom_re(idx_up);
    assign im_lo  = rom_im(idx_reg);
    assign im_hi  = rom_im(idx_up);

    assign sum_re = NUM_W'(PROD_W'(re_lo) * PROD_W'(to_hi_reg))
                  + NUM_W'(PROD_W'(re_hi) * PROD_W'(from_lo_reg));
    assign sum_im = NUM_W'(PROD_W'(im_lo) * PROD_W'(to_hi_reg))
                  + NUM_W'(PROD_W'(im_hi) * PROD_W'(from_lo_reg));

    assign step_re    = div_bit(rem_re_reg, nq_re_reg[INDEX_W-1], width_reg);
    assign step_im    = div_bit(rem_im_reg, nq_im_reg[INDEX_W-1], width_reg);
    assign width_zero = (width_reg == '0);

    assign st.below    = x_reg < rom_wave('0);
    assign st.above    = x_reg > rom_wave(LAST_IDX);
    assign st.seg_hit  = x_reg <= w_hi;
    assign st.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.seg_next)
        begin
            idx_next = idx_up;
        end
        if (cmd.load_div)
        begin
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= wavelength;
        end
        if (cmd.load_mul)
        begin
            from_lo_reg <= x_reg - w_lo;
            to_hi_reg   <= w_hi - x_reg;
            width_reg   <= w_hi - w_lo;
        end
        if (cmd.load_div)
        begin
            rem_re_reg <= sum_re[INDEX_W+WAVE_W-1:INDEX_W];
            rem_im_reg <= sum_im[INDEX_W+WAVE_W-1:INDEX_W];
            nq_re_reg  <= sum_re[INDEX_W-1:0];
            nq_im_reg  <= sum_im[INDEX_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_re_reg <= step_re[WAVE_W-1:0];
            rem_im_reg <= step_im[WAVE_W-1:0];
            nq_re_reg  <= {nq_re_reg[INDEX_W-2:0], step_re[WAVE_W]};
            nq_im_reg  <= {nq_im_reg[INDEX_W-2:0], step_im[WAVE_W]};
        end
        if (cmd.emit_clamp)
        begin
            if (st.below)
            begin
                real_reg   <= rom_re('0);
                imag_reg   <= rom_im('0);
                status_reg <= STATUS_LOW;
            end
            else
            begin
                real_reg   <= rom_re(LAST_IDX);
                imag_reg   <= rom_im(LAST_IDX);
                status_reg <= STATUS_HIGH;
            end
        end
        else if (cmd.emit_interp)
        begin
            real_reg   <= width_zero ? re_lo : nq_re_reg;
            imag_reg   <= width_zero ? im_lo : nq_im_reg;
            status_reg <= STATUS_INTERP;
        end
    end

    assign index_real   = real_reg;
    assign index_imag   = imag_reg;
    assign range_status = status_reg;

endmodule

`default_nettype wire

// File: design/rii_ctrl.sv
// ----------------------------------------------------------------------------
// rii_ctrl
// Sequencer for range check, segment search, multiply and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refractive_index_interpolator_assert.svh"

module rii_ctrl
    import rii_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire rii_stat_t st,
    output rii_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_SEARCH,
        S_MULT,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg,  done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (st.below || st.above)
                begin
                    cmd.emit_clamp = 1'b1;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (st.seg_hit)
                begin
                    cmd.load_mul = 1'b1;
                    state_next   = S_MULT;
                end
                else
                begin
                    cmd.seg_next = 1'b1;
                end
            end
            S_MULT:
            begin
                cmd.load_div = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_interp = 1'b1;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `RII_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy,
        "accepted beat did not raise busy")
    `RII_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy,
        "result strobe while still busy")
    `RII_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done,
        "result strobe longer than one cycle")
    `RII_ASSERT_IMPLY(a_search_bound, clk, rst_n, state_reg == S_SEARCH,
        !(st.below || st.above), "segment search on clamped input")

endmodule

`default_nettype wire

// File: design/refractive_index_interpolator.sv
// ----------------------------------------------------------------------------
// refractive_index_interpolator
// Piecewise linear lookup of complex refractive index by wavelength.
// ----------------------------------------------------------------------------
// Usage:
//   Drive wavelength (0.1 nm units) and pulse start while busy is low; the
//   beat is taken at that edge and busy rises the next cycle.
//   One result beat follows: done is high for exactly one cycle with
//   index_real, index_imag (unsigned Q3.16) and range_status valid. The
//   result ports hold their value until the next result.
//   From the accepting edge, a clamped input goes from the range check
//   straight to the result; an interpolated one passes a range check,
//   1 to 13 segment search steps (one table entry per cycle), a multiply,
//   19 divide steps and an emit. The dividers are bit-serial restoring
//   dividers, one quotient bit per cycle; the segment walk is linear.
//   Throughput: one item at a time; a new start is taken the cycle done
//   is high.
//   Reset returns the sequencer to idle with done low; no table clearing.
//   The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module refractive_index_interpolator
    import rii_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output logic                     done,
    input  wire logic [WAVE_W-1:0]   wavelength,
    output logic [INDEX_W-1:0]       index_real,
    output logic [INDEX_W-1:0]       index_imag,
    output logic [STATUS_W-1:0]      range_status
);

    rii_cmd_t  cmd;
    rii_stat_t st;

    rii_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    rii_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .wavelength   (wavelength),
        .cmd          (cmd),
        .st           (st),
        .index_real   (index_real),
        .index_imag   (index_imag),
        .range_status (range_status)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: refractive index interpolator regression
// Drives wavelength beats through the start/busy handshake and checks every
// done beat against its typed row or an in-bench piecewise linear predictor.
// Directed rows cover clamping, exact endpoints and segment boundaries. Random
// beats cover the full input range with random idle gaps and back-to-back runs.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rii_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 1230;
    localparam int TAIL_CYCLES  = 40;
    localparam int KNOT_COUNT   = (TABLE_ENTRIES_DEF > ROM_DEPTH) ? ROM_DEPTH :
                                  (TABLE_ENTRIES_DEF < 2) ? 2 : TABLE_ENTRIES_DEF;
    localparam int KNOT_LAST    = KNOT_COUNT - 1;

    localparam logic [13:0][WAVE_W-1:0] KNOT_WAVE = {
        16'd9613, 16'd8190, 16'd6199, 16'd4960, 16'd4133, 16'd3543, 16'd3100,
        16'd2755, 16'd2480, 16'd2066, 16'd1771, 16'd1550, 16'd1378, 16'd1240
    };
    localparam logic [13:0][INDEX_W-1:0] KNOT_RE = {
        19'd239862, 19'd255590, 19'd308675, 19'd344064, 19'd355860, 19'd300810,
        19'd220201, 19'd151388, 19'd108790, 19'd62980, 19'd43909, 19'd36307,
        19'd32702, 19'd30540
    };
    localparam logic [13:0][INDEX_W-1:0] KNOT_IM = {
        19'd721, 19'd1461, 19'd14221, 19'd65012, 19'd143524, 19'd221512,
        19'd256901, 19'd243139, 19'd221512, 19'd173670, 19'd136315, 19'd108790,
        19'd87163, 19'd71434
    };

    typedef struct packed {
        logic [WAVE_W-1:0]   wave;
        logic [INDEX_W-1:0]  re;
        logic [INDEX_W-1:0]  im;
        logic [STATUS_W-1:0] status;
    } index_beat_t;

    typedef struct packed {
        bit          typed;
        index_beat_t beat;
    } wave_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                done;
    logic [WAVE_W-1:0]   wavelength;
    logic [INDEX_W-1:0]  index_real;
    logic [INDEX_W-1:0]  index_imag;
    logic [STATUS_W-1:0] range_status;

    index_beat_t index_pending[$];
    wave_row_t   directed_rows[$];
    int          cycle_count   = 0;
    int          err_count     = 0;
    int          beats_checked = 0;
    int          interp_seen   = 0;
    int          low_seen      = 0;
    int          high_seen     = 0;
    int          knot_hits     = 0;

    refractive_index_interpolator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .wavelength   (wavelength),
        .index_real   (index_real),
        .index_imag   (index_imag),
        .range_status (range_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic index_beat_t predict_index(input logic [WAVE_W-1:0] w);
        index_beat_t r;
        logic [63:0] num_re;
        logic [63:0] num_im;
        logic [63:0] from_lo;
        logic [63:0] to_hi;
        logic [63:0] span;
        bit          found;
        r = '0;
        r.wave = w;
        found = 1'b0;
        if (w < KNOT_WAVE[0])
        begin
            r.re = KNOT_RE[0];
            r.im = KNOT_IM[0];
            r.status = STATUS_LOW;
        end
        else if (w > KNOT_WAVE[KNOT_LAST])
        begin
            r.re = KNOT_RE[KNOT_LAST];
            r.im = KNOT_IM[KNOT_LAST];
            r.status = STATUS_HIGH;
        end
        else
        begin
            r.status = STATUS_INTERP;
            for (int seg = 0; seg < KNOT_LAST; seg++)
            begin
                if (!found && w >= KNOT_WAVE[seg] && w <= KNOT_WAVE[seg+1])
                begin
                    found = 1'b1;
                    from_lo = 64'(w - KNOT_WAVE[seg]);
                    to_hi = 64'(KNOT_WAVE[seg+1] - w);
                    span = 64'(KNOT_WAVE[seg+1] - KNOT_WAVE[seg]);
                    if (span == 64'd0)
                    begin
                        r.re = KNOT_RE[seg];
                        r.im = KNOT_IM[seg];
                    end
                    else
                    begin
                        num_re = 64'(KNOT_RE[seg]) * to_hi + 64'(KNOT_RE[seg+1]) * from_lo;
                        num_im = 64'(KNOT_IM[seg]) * to_hi + 64'(KNOT_IM[seg+1]) * from_lo;
                        r.re = INDEX_W'(num_re / span);
                        r.im = INDEX_W'(num_im / span);
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void add_row(input wave_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    task automatic issue_beat(input wave_row_t row);
        index_beat_t want;
        start <= 1'b1;
        wavelength <= row.beat.wave;
        do @(posedge clk); while (busy);
        want = row.typed ? row.beat : predict_index(row.beat.wave);
        want.wave = row.beat.wave;
        index_pending = {index_pending, want};
    endtask

    task automatic hold_gap(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            wavelength <= WAVE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        while (index_pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [WAVE_W-1:0] pick_wave();
        int mode;
        int knot;
        mode = $urandom_range(0, 99);
        if (mode < 60)
            return WAVE_W'($urandom_range(KNOT_WAVE[0], KNOT_WAVE[KNOT_LAST]));
        if (mode < 80)
        begin
            knot = $urandom_range(0, KNOT_LAST);
            return WAVE_W'(int'(KNOT_WAVE[knot]) + $urandom_range(0, 4) - 2);
        end
        if (mode < 95)
            return WAVE_W'($urandom_range(0, 65535));
        return WAVE_W'($urandom_range(0, KNOT_WAVE[0]));
    endfunction

    // check each done beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (index_pending.size() == 0)
            begin
                $display("%0t: unexpected result beat: real %0d imag %0d status %0d",
                         $time, index_real, index_imag, range_status);
                err_count++;
            end
            else
            begin
                index_beat_t want;
                want = index_pending.pop_front();
                beats_checked++;
                if (index_real !== want.re)
                begin
                    $display("%0t: index_real for wavelength %0d: expected %0d, actual %0d",
                             $time, want.wave, want.re, index_real);
                    err_count++;
                end
                if (index_imag !== want.im)
                begin
                    $display("%0t: index_imag for wavelength %0d: expected %0d, actual %0d",
                             $time, want.wave, want.im, index_imag);
                    err_count++;
                end
                if (range_status !== want.status)
                begin
                    $display("%0t: range_status for wavelength %0d: expected %0d, actual %0d",
                             $time, want.wave, want.status, range_status);
                    err_count++;
                end
                case (want.status)
                    STATUS_LOW:  low_seen++;
                    STATUS_HIGH: high_seen++;
                    default:     interp_seen++;
                endcase
                for (int k = 0; k <= KNOT_LAST; k++)
                    if (want.wave == KNOT_WAVE[k])
                        knot_hits++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, index_pending.size());
            $display("refractive_index_interpolator regression: fail");
            $finish;
        end
    end

    initial
    begin
        int burst_left;
        int gap;
        wave_row_t row;
        rst_n = 1'b0;
        start = 1'b0;
        wavelength = '0;
        burst_left = 0;

        add_row('{1'b1, '{16'd0,     19'd30540,  19'd71434, STATUS_LOW}});
        add_row('{1'b1, '{16'd65535, 19'd239862, 19'd721,   STATUS_HIGH}});
        add_row('{1'b1, '{16'd1239,  19'd30540,  19'd71434, STATUS_LOW}});
        add_row('{1'b1, '{16'd1240,  19'd30540,  19'd71434, STATUS_INTERP}});
        add_row('{1'b1, '{16'd9613,  19'd239862, 19'd721,   STATUS_INTERP}});
        add_row('{1'b1, '{16'd9614,  19'd239862, 19'd721,   STATUS_HIGH}});
        add_row('{1'b1, '{16'd1378,  19'd32702,  19'd87163, STATUS_INTERP}});
        add_row('{1'b1, '{16'd4960,  19'd344064, 19'd65012, STATUS_INTERP}});
        add_row('{1'b1, '{16'd8190,  19'd255590, 19'd1461,  STATUS_INTERP}});
        add_row('{1'b1, '{16'hAAAA,  19'd239862, 19'd721,   STATUS_HIGH}});
        add_row('{1'b1, '{16'h5555,  19'd239862, 19'd721,   STATUS_HIGH}});
        add_row('{1'b0, '{16'd1241,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd1309,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd1379,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd2066,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd2480,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd3100,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd5000,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'h1555,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd6199,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd7000,  19'd0, 19'd0, STATUS_INTERP}});
        add_row('{1'b0, '{16'd9612,  19'd0, 19'd0, STATUS_INTERP}});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            issue_beat(directed_rows[i]);
            hold_gap($urandom_range(0, 18));
        end
        drain_pending();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            row = '0;
            row.beat.wave = pick_wave();
            issue_beat(row);
            if (n % 200 == 199)
                drain_pending();
            else
            begin
                if (burst_left == 0 && $urandom_range(0, 3) == 0)
                    burst_left = $urandom_range(10, 40);
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else
                    gap = $urandom_range(0, 18);
                hold_gap(gap);
            end
        end

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d result beats: %0d interpolated, %0d clamped low, %0d clamped high",
                 beats_checked, interp_seen, low_seen, high_seen);
        $display("table knots hit exactly %0d times, %0d mismatches", knot_hits, err_count);
        if (err_count == 0 && index_pending.size() == 0)
            $display("refractive_index_interpolator regression: pass");
        else
            $display("refractive_index_interpolator regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/rii_pkg.sv
design/rii_datapath.sv
design/rii_ctrl.sv
design/refractive_index_interpolator.sv
tb/tb_top.sv
